FILE: rtl/core/bsm_pkg.sv
// Shared constants, types and fixed-point helpers for the bezel shadow mask pixel core.
package bsm_pkg;

  localparam int unsigned MAX_DIMENSION = 4096;

  localparam int unsigned DIM_W = 13;  // configured panel sides
  localparam int unsigned CRD_W = 12;  // pixel coordinates
  localparam int unsigned RES_W = 8;   // reserved thickness
  localparam int unsigned STR_W = 17;  // strength, Q1.16
  localparam int unsigned IDX_W = 2;   // register index
  localparam int unsigned C_W   = 10;  // frame thickness
  localparam int unsigned DEN_W = 13;  // 12 * thickness
  localparam int unsigned QT_W  = 16;  // divider quotient bits

  // register indexes
  localparam logic [IDX_W-1:0] REG_WIDTH    = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT   = 2'd1;
  localparam logic [IDX_W-1:0] REG_RESERVED = 2'd2;
  localparam logic [IDX_W-1:0] REG_STRENGTH = 2'd3;

  // Q2.16 constants
  localparam logic [17:0] Q_ONE        = 18'd65536;
  localparam logic [17:0] K_LIP_TOP    = 18'd28246;
  localparam logic [17:0] K_LIP_CORNER = 18'd4588;
  localparam logic [17:0] K_LIP_LEFT   = 18'd17498;
  localparam logic [17:0] K_UNDER_BOT  = 18'd524;
  localparam logic [17:0] K_UNDER_RGT  = 18'd1180;
  localparam logic [17:0] K_BODY_DARK  = 18'd58982;
  localparam logic [17:0] K_W062       = 18'd40632;
  localparam logic [17:0] K_W034       = 18'd22282;
  localparam logic [17:0] K_DEEP       = 18'd19661;

  // per-pixel tone carried beside the dial datapath
  typedef struct packed {
    logic       dial;
    logic [7:0] add;
    logic [7:0] mul;
  } sb_t;

  // Q16 product rounded half-up
  function automatic logic [19:0] qmul(input logic [17:0] a, input logic [17:0] b);
    logic [36:0] p;
    p = 37'(a) * 37'(b) + 37'd32768;
    return p[35:16];
  endfunction

  // Q16 value to a byte, rounded and clamped
  function automatic logic [7:0] to_byte(input logic [17:0] v);
    logic [25:0] p;
    p = {8'd0, v} * 26'd255 + 26'd32768;
    if (v >= Q_ONE) return 8'd255;
    return p[23:16];
  endfunction

endpackage

FILE: rtl/core/bsm_if.sv
// Channel interfaces of the bezel shadow mask pixel core.
interface bsm_pix_if;
  logic                        valid;
  logic                        ready;
  logic [bsm_pkg::CRD_W-1:0]   pixel_x;
  logic [bsm_pkg::CRD_W-1:0]   pixel_y;
  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface bsm_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] add_value;
  logic [7:0] mul_value;
  modport source (output valid, add_value, mul_value, input ready);
  modport sink   (input valid, add_value, mul_value, output ready);
endinterface

interface bsm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bsm_pkg::IDX_W-1:0]   index;
  logic [bsm_pkg::STR_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/bezel_shadow_mask_pixel_core.sv
// Bezel shadow mask pixel core: 26-stage pipeline, one pixel per clock while the result
// sink is ready and setup is idle. Each side has its own 16-stage restoring divider,
// one quotient bit per stage. Registers reset to zero.
// Each stage holds when the next is full and stalled, so bubbles collapse.
// After reset and after every register write a setup sequence of load, divide,
// finish and byte states derives the frame thickness; pixel input is held off meanwhile.
module bezel_shadow_mask_pixel_core #(
  parameter int unsigned MaxDim = bsm_pkg::MAX_DIMENSION
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bsm_cfg_if.sink       cfg_i,
  bsm_pix_if.sink       pix_i,
  bsm_res_if.source     res_o
);

  localparam int unsigned DW   = bsm_pkg::DIM_W;
  localparam int unsigned CW   = bsm_pkg::C_W;
  localparam int unsigned NW   = bsm_pkg::DEN_W;
  localparam int unsigned QW   = bsm_pkg::QT_W;
  localparam int unsigned CAP  = (MaxDim > 8191) ? 8191 : MaxDim;
  localparam logic [DW-1:0] DIM_CAP = CAP[DW-1:0];
  localparam int unsigned NS   = QW + 10;  // pipeline stages
  localparam int unsigned D0   = 1;        // first divider stage index
  localparam int unsigned ST   = D0 + QW + 1;  // first stage after the divider
  localparam int unsigned DVW  = 23;       // setup dividend width
  // ceil(2^36 / 10000): exact floor division for dividends below 2^23
  localparam logic [DVW-1:0] RECIP_10K = 23'd6871948;
  localparam int unsigned    RECIP_SH  = 36;

  // ---------------- configuration registers ----------------
  logic [DW-1:0]                 width_q, height_q;
  logic [bsm_pkg::RES_W-1:0]     resv_q;
  logic [bsm_pkg::STR_W-1:0]     str_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
      resv_q   <= '0;
      str_q    <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        bsm_pkg::REG_WIDTH:    width_q  <= cfg_i.data[DW-1:0];
        bsm_pkg::REG_HEIGHT:   height_q <= cfg_i.data[DW-1:0];
        bsm_pkg::REG_RESERVED: resv_q   <= cfg_i.data[bsm_pkg::RES_W-1:0];
        bsm_pkg::REG_STRENGTH: str_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // saturated views
  logic [DW-1:0] w_eff, h_eff, short_side;
  logic [17:0]   s_eff;
  assign w_eff      = (width_q > DIM_CAP) ? DIM_CAP : width_q;
  assign h_eff      = (height_q > DIM_CAP) ? DIM_CAP : height_q;
  assign short_side = (w_eff < h_eff) ? w_eff : h_eff;
  assign s_eff      = ({1'b0, str_q} > bsm_pkg::Q_ONE) ? bsm_pkg::Q_ONE : {1'b0, str_q};

  // ---------------- setup sequencer ----------------
  typedef enum logic [2:0] {CS_LOAD, CS_DIV, CS_FIN, CS_BYTE, CS_IDLE} cstate_e;

  cstate_e          cst_q;
  logic [DVW-1:0]   dvd_q;
  logic [CW-1:0]    c_q;
  logic [NW-1:0]    den_q;
  logic [17:0]      pb_q, pa_bot_q, pa_rgt_q, pa_top_q, pa_cnr_q, pa_lft_q;
  logic [7:0]       mul_bez_q, add_bot_q, add_rgt_q, add_top_q, add_cnr_q, add_lft_q;

  logic [45:0]      quot_full;
  logic [DVW-1:0]   load_dvd;
  logic [CW-1:0]    c_fb, c_req, c_fin;
  logic [DW-2:0]    lim_w, lim_h;
  logic [15:0]      den_full;

  always_comb begin
    quot_full = 46'(dvd_q) * 46'(RECIP_10K);
    load_dvd  = DVW'({10'd0, short_side} * 23'd667) + DVW'(5000);
    c_fb      = (dvd_q < DVW'(2)) ? CW'(2) : dvd_q[CW-1:0];
    c_req     = (resv_q != '0) ? CW'(resv_q) : c_fb;
    lim_w     = (DW-1)'((w_eff - DW'(2)) >> 1);
    lim_h     = (DW-1)'((h_eff - DW'(2)) >> 1);
    c_fin     = c_req;
    if (lim_w < (DW-1)'(c_fin)) c_fin = CW'(lim_w);
    if (lim_h < (DW-1)'(c_fin)) c_fin = CW'(lim_h);
    if (w_eff < DW'(2) || h_eff < DW'(2)) c_fin = '0;
    den_full  = 16'(c_q) * 16'd12;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cst_q <= CS_LOAD;
    end else if (cfg_i.valid) begin
      cst_q <= CS_LOAD;
    end else begin
      unique case (cst_q)
        CS_LOAD: begin
          dvd_q <= load_dvd;
          cst_q <= CS_DIV;
        end
        // divide by 10000 through the reciprocal
        CS_DIV: begin
          dvd_q <= DVW'(quot_full >> RECIP_SH);
          cst_q <= CS_FIN;
        end
        CS_FIN: begin
          c_q      <= c_fin;
          pb_q     <= 18'(bsm_pkg::qmul(bsm_pkg::K_BODY_DARK, s_eff));
          pa_bot_q <= 18'(bsm_pkg::qmul(bsm_pkg::K_UNDER_BOT, s_eff));
          pa_rgt_q <= 18'(bsm_pkg::qmul(bsm_pkg::K_UNDER_RGT, s_eff));
          pa_top_q <= 18'(bsm_pkg::qmul(bsm_pkg::K_LIP_TOP, s_eff));
          pa_cnr_q <= 18'(bsm_pkg::qmul(bsm_pkg::K_LIP_TOP + bsm_pkg::K_LIP_CORNER,
                                        s_eff));
          pa_lft_q <= 18'(bsm_pkg::qmul(bsm_pkg::K_LIP_LEFT, s_eff));
          cst_q    <= CS_BYTE;
        end
        CS_BYTE: begin
          den_q     <= den_full[NW-1:0];
          mul_bez_q <= bsm_pkg::to_byte(bsm_pkg::Q_ONE - pb_q);
          add_bot_q <= bsm_pkg::to_byte(pa_bot_q);
          add_rgt_q <= bsm_pkg::to_byte(pa_rgt_q);
          add_top_q <= bsm_pkg::to_byte(pa_top_q);
          add_cnr_q <= bsm_pkg::to_byte(pa_cnr_q);
          add_lft_q <= bsm_pkg::to_byte(pa_lft_q);
          cst_q     <= CS_IDLE;
        end
        CS_IDLE: ;
        default: cst_q <= CS_LOAD;
      endcase
    end
  end

  // ---------------- pipeline flow control ----------------
  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  assign en[NS] = res_o.ready;
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = ~v_q[k] | en[k+1];
  end

  assign pix_i.ready = en[0] & (cst_q == CS_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= pix_i.valid & pix_i.ready;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // ---------------- stage 0: input register ----------------
  logic [bsm_pkg::CRD_W-1:0] x0_q, y0_q;
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x0_q <= pix_i.pixel_x;
      y0_q <= pix_i.pixel_y;
    end
  end

  // ---------------- stage 1: classify, seed dividers ----------------
  // side order: top, left, bottom, right
  bsm_pkg::sb_t  sb_q [NS];
  logic [NW-1:0] rem_q [QW+1][4];
  logic [QW-1:0] quo_q [QW+1][4];
  logic          sat_q [QW+1][4];

  logic [DW-1:0]  edg [4];
  logic [DW-1:0]  ring, lit, shd;
  logic           outside;
  bsm_pkg::sb_t   sb1;
  logic [DW-1:0]  diff [4];
  logic [15:0]    num  [4];
  logic           sat1 [4];

  always_comb begin
    edg[0] = DW'(y0_q);
    edg[1] = DW'(x0_q);
    edg[2] = DW'(h_eff - DW'(1) - DW'(y0_q));
    edg[3] = DW'(w_eff - DW'(1) - DW'(x0_q));
    outside = (s_eff == '0) || (w_eff == '0) || (h_eff == '0) ||
              (DW'(x0_q) >= w_eff) || (DW'(y0_q) >= h_eff) || (c_q == '0);
    lit  = (edg[0] < edg[1]) ? edg[0] : edg[1];
    shd  = (edg[2] < edg[3]) ? edg[2] : edg[3];
    ring = (lit < shd) ? lit : shd;
    sb1.dial = 1'b0;
    sb1.add  = 8'd0;
    sb1.mul  = 8'd255;
    if (!outside && ring != '0) begin
      if (ring < DW'(c_q)) begin
        sb1.mul = mul_bez_q;
        if (shd <= lit)
          sb1.add = (edg[2] <= edg[3]) ? add_bot_q : add_rgt_q;
        else if (edg[0] < DW'(c_q) && edg[1] < DW'(c_q))
          sb1.add = add_cnr_q;
        else if (edg[0] <= edg[1])
          sb1.add = add_top_q;
        else
          sb1.add = add_lft_q;
      end else begin
        sb1.dial = 1'b1;
      end
    end
    for (int s = 0; s < 4; s++) begin
      diff[s] = edg[s] - DW'(c_q);
      num[s]  = 16'(diff[s]) * 16'd5;
      sat1[s] = (num[s] >= 16'(den_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[D0]) begin
      sb_q[D0] <= sb1;
      for (int s = 0; s < 4; s++) begin
        rem_q[0][s] <= sat1[s] ? '0 : num[s][NW-1:0];
        quo_q[0][s] <= '0;
        sat_q[0][s] <= sat1[s];
      end
    end
  end

  // ---------------- divider stages: one quotient bit each ----------------
  for (genvar j = 1; j <= QW; j++) begin : g_div
    logic [NW:0] r2 [4];
    logic        ge [4];
    always_comb begin
      for (int s = 0; s < 4; s++) begin
        r2[s] = {rem_q[j-1][s], 1'b0};
        ge[s] = (r2[s] >= {1'b0, den_q});
      end
    end
    always_ff @(posedge clk_i) begin
      if (en[D0+j]) begin
        sb_q[D0+j] <= sb_q[D0+j-1];
        for (int s = 0; s < 4; s++) begin
          rem_q[j][s] <= ge[s] ? NW'(r2[s] - {1'b0, den_q}) : r2[s][NW-1:0];
          quo_q[j][s] <= {quo_q[j-1][s][QW-2:0], ge[s]};
          sat_q[j][s] <= sat_q[j-1][s];
        end
      end
    end
  end

  // ---------------- smoothstep and shade stages ----------------
  logic [17:0] t_q [4], t2_q [4], d_q [4], dsq_q [4];
  logic [17:0] ql_q, qr_q, dt_q, db_q, p34_q, part_q, ds_q, vm_q;
  logic [17:0] t_n [4];
  logic [19:0] s_n [4];
  logic [18:0] inner, shade_sum;
  logic [17:0] shade;
  logic [19:0] dark;
  logic [7:0]  mul_fin;

  always_comb begin
    for (int s = 0; s < 4; s++) begin
      t_n[s] = sat_q[QW][s] ? bsm_pkg::Q_ONE : {2'b00, quo_q[QW][s]};
      s_n[s] = bsm_pkg::qmul(t2_q[s], 18'(3 * 65536) - {t_q[s][16:0], 1'b0});
    end
    inner     = {1'b0, db_q} + {1'b0, qr_q};
    shade_sum = {1'b0, part_q} + {1'b0, p34_q};
    shade     = (shade_sum > 19'(bsm_pkg::Q_ONE)) ? bsm_pkg::Q_ONE : shade_sum[17:0];
    dark      = bsm_pkg::qmul(ds_q, s_eff);
    mul_fin   = sb_q[NS-2].dial ? bsm_pkg::to_byte(vm_q) : sb_q[NS-2].mul;
  end

  always_ff @(posedge clk_i) begin
    // t and t squared
    if (en[ST]) begin
      sb_q[ST] <= sb_q[ST-1];
      for (int s = 0; s < 4; s++) begin
        t_q[s]  <= t_n[s];
        t2_q[s] <= 18'(bsm_pkg::qmul(t_n[s], t_n[s]));
      end
    end
    // smoothstep, clamped, complemented
    if (en[ST+1]) begin
      sb_q[ST+1] <= sb_q[ST];
      for (int s = 0; s < 4; s++) begin
        d_q[s] <= (s_n[s] > 20'(bsm_pkg::Q_ONE)) ? '0 :
                  18'(bsm_pkg::Q_ONE - s_n[s][17:0]);
      end
    end
    // squared falloff
    if (en[ST+2]) begin
      sb_q[ST+2] <= sb_q[ST+1];
      for (int s = 0; s < 4; s++) begin
        dsq_q[s] <= 18'(bsm_pkg::qmul(d_q[s], d_q[s]));
      end
    end
    // side weights
    if (en[ST+3]) begin
      sb_q[ST+3] <= sb_q[ST+2];
      dt_q <= dsq_q[0];
      db_q <= dsq_q[2];
      ql_q <= 18'(bsm_pkg::qmul(bsm_pkg::K_W062, dsq_q[1]));
      qr_q <= 18'(bsm_pkg::qmul(bsm_pkg::K_W062, dsq_q[3]));
    end
    // upper pair sum, lower pair weight
    if (en[ST+4]) begin
      sb_q[ST+4] <= sb_q[ST+3];
      part_q <= 18'({1'b0, dt_q} + {1'b0, ql_q});
      p34_q  <= 18'(bsm_pkg::qmul(bsm_pkg::K_W034, 18'(inner)));
    end
    // saturate shade, deepen
    if (en[ST+5]) begin
      sb_q[ST+5] <= sb_q[ST+4];
      ds_q <= 18'(bsm_pkg::qmul(bsm_pkg::K_DEEP, shade));
    end
    // strength, clamp, complement
    if (en[ST+6]) begin
      sb_q[ST+6] <= sb_q[ST+5];
      vm_q <= (dark > 20'(bsm_pkg::Q_ONE)) ? '0 : 18'(bsm_pkg::Q_ONE - dark[17:0]);
    end
    // output register
    if (en[NS-1]) begin
      sb_q[NS-1].dial <= sb_q[NS-2].dial;
      sb_q[NS-1].add  <= sb_q[NS-2].add;
      sb_q[NS-1].mul  <= mul_fin;
    end
  end

  assign res_o.valid     = v_q[NS-1];
  assign res_o.add_value = sb_q[NS-1].add;
  assign res_o.mul_value = sb_q[NS-1].mul;

endmodule

FILE: sim/tb_bezel_shadow_mask_pixel_core.sv
// Self-checking testbench for the bezel shadow mask pixel core.
module tb_bezel_shadow_mask_pixel_core;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned CW = bsm_pkg::CRD_W;
  localparam int unsigned SW = bsm_pkg::STR_W;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
  } coord_t;

  typedef struct packed {
    logic [7:0] add;
    logic [7:0] mul;
  } tone_t;

  logic clk_i;
  logic rst_ni;

  bsm_cfg_if cfg ();
  bsm_pix_if pix ();
  bsm_res_if res ();

  bezel_shadow_mask_pixel_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .pix_i  (pix),
    .res_o  (res)
  );

  // shadow copy of the panel registers
  logic [bsm_pkg::DIM_W-1:0] panel_w;
  logic [bsm_pkg::DIM_W-1:0] panel_h;
  logic [bsm_pkg::RES_W-1:0] frame_req;
  logic [SW-1:0]             strength;

  coord_t      pixel_queue[$];
  tone_t       tone_queue[$];
  int unsigned mismatches;
  int unsigned pixels_sent;
  int unsigned tones_checked;
  int unsigned phases_run;
  int unsigned idle_cycles;

  // clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Q16 product, rounded half-up
  function automatic longint unsigned q16_mul(input longint unsigned a,
                                              input longint unsigned b);
    return (a * b + 64'd32768) >> 16;
  endfunction

  function automatic logic [7:0] q16_byte(input longint unsigned v);
    longint unsigned r;
    if (v == 0) return 8'd0;
    if (v >= 65536) return 8'd255;
    r = (v * 255 + 64'd32768) >> 16;
    return 8'(r);
  endfunction

  // squared falloff of the dial shadow from one inner bezel face
  function automatic longint unsigned face_falloff(input longint unsigned e,
                                                   input longint unsigned c);
    longint unsigned num, den, t, t2, s, d;
    num = 5 * (e - c);
    den = 12 * c;
    t   = (num >= den) ? 64'd65536 : (num * 65536) / den;
    t2  = q16_mul(t, t);
    s   = q16_mul(t2, 3 * 65536 - 2 * t);
    if (s > 65536) s = 65536;
    d = 65536 - s;
    return q16_mul(d, d);
  endfunction

  function automatic longint unsigned frame_size(input longint unsigned w,
                                                 input longint unsigned h);
    longint unsigned c;
    if (frame_req != 0) begin
      c = frame_req;
    end else begin
      c = (((w < h) ? w : h) * 667 + 5000) / 10000;
      if (c < 2) c = 2;
    end
    if (w < 2 || h < 2) return 0;
    if (c > (w - 2) / 2) c = (w - 2) / 2;
    if (c > (h - 2) / 2) c = (h - 2) / 2;
    return c;
  endfunction

  function automatic tone_t bezel_tone(input coord_t p);
    longint unsigned w, h, s, c, et, eb, el, er, ring, lit, shd, a;
    longint unsigned dt, dl, db, dr, shade, dark;
    tone_t t;
    w = (panel_w > bsm_pkg::MAX_DIMENSION) ? bsm_pkg::MAX_DIMENSION : panel_w;
    h = (panel_h > bsm_pkg::MAX_DIMENSION) ? bsm_pkg::MAX_DIMENSION : panel_h;
    s = (strength > 65536) ? 65536 : strength;
    t.add = 8'd0;
    t.mul = 8'd255;
    if (s == 0 || w == 0 || h == 0 || p.x >= w || p.y >= h) return t;
    c = frame_size(w, h);
    if (c == 0) return t;
    et = p.y;
    eb = h - 1 - p.y;
    el = p.x;
    er = w - 1 - p.x;
    ring = et;
    if (eb < ring) ring = eb;
    if (el < ring) ring = el;
    if (er < ring) ring = er;
    if (ring == 0) return t;
    if (ring < c) begin
      lit = (et < el) ? et : el;
      shd = (eb < er) ? eb : er;
      if (shd <= lit) a = (eb <= er) ? bsm_pkg::K_UNDER_BOT : bsm_pkg::K_UNDER_RGT;
      else if (et < c && el < c) a = bsm_pkg::K_LIP_TOP + bsm_pkg::K_LIP_CORNER;
      else if (et <= el) a = bsm_pkg::K_LIP_TOP;
      else a = bsm_pkg::K_LIP_LEFT;
      t.mul = q16_byte(65536 - q16_mul(bsm_pkg::K_BODY_DARK, s));
      t.add = q16_byte(q16_mul(a, s));
    end else begin
      dt = face_falloff(et, c);
      dl = face_falloff(el, c);
      db = face_falloff(eb, c);
      dr = face_falloff(er, c);
      shade = dt + q16_mul(bsm_pkg::K_W062, dl) +
              q16_mul(bsm_pkg::K_W034, db + q16_mul(bsm_pkg::K_W062, dr));
      if (shade > 65536) shade = 65536;
      dark = q16_mul(q16_mul(bsm_pkg::K_DEEP, shade), s);
      if (dark > 65536) dark = 65536;
      t.mul = q16_byte(65536 - dark);
      t.add = 8'd0;
    end
    return t;
  endfunction

  // pixel driver: bursts of random length with random gaps
  int unsigned burst_left;
  int unsigned gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    coord_t p;
    if (!rst_ni) begin
      pix.valid   <= 1'b0;
      pix.pixel_x <= '0;
      pix.pixel_y <= '0;
      burst_left  = 1;
      gap_left    = 0;
    end else if (!pix.valid || pix.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        pix.valid <= 1'b0;
      end else if (pixel_queue.size() > 0) begin
        p = pixel_queue.pop_front();
        pix.valid   <= 1'b1;
        pix.pixel_x <= p.x;
        pix.pixel_y <= p.y;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  // result sink stalls from a rotating pattern, reloaded now and then
  logic [15:0] stall_pattern;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_pattern <= 16'hffff;
      res.ready     <= 1'b0;
    end else begin
      if ($urandom_range(0, 31) == 0)
        stall_pattern <= ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom);
      else
        stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
      res.ready <= stall_pattern[15];
    end
  end

  // monitor: predict on pixel transactions, check on result transactions
  always @(posedge clk_i) begin
    coord_t p;
    tone_t  want;
    if (rst_ni) begin
      if (pix.valid && pix.ready) begin
        p.x = pix.pixel_x;
        p.y = pix.pixel_y;
        tone_queue.push_back(bezel_tone(p));
        pixels_sent++;
      end
      if (res.valid && res.ready) begin
        if (tone_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result add=%0d mul=%0d", res.add_value, res.mul_value);
        end else begin
          want = tone_queue.pop_front();
          tones_checked++;
          if (res.add_value !== want.add || res.mul_value !== want.mul) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: add exp %0d got %0d, mul exp %0d got %0d",
                       want.add, res.add_value, want.mul, res.mul_value);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk_i) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d results outstanding", tone_queue.size());
      $display("FAIL bezel_shadow_mask_pixel_core");
      $finish;
    end
  end

  // one register write, valid left high for the caller to drop
  task automatic write_reg(input logic [bsm_pkg::IDX_W-1:0] idx,
                           input logic [SW-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk_i); while (!cfg.ready);
    case (idx)
      bsm_pkg::REG_WIDTH:    panel_w   = value[bsm_pkg::DIM_W-1:0];
      bsm_pkg::REG_HEIGHT:   panel_h   = value[bsm_pkg::DIM_W-1:0];
      bsm_pkg::REG_RESERVED: frame_req = value[bsm_pkg::RES_W-1:0];
      bsm_pkg::REG_STRENGTH: strength  = value;
      default: ;
    endcase
  endtask

  task automatic set_panel(input logic [SW-1:0] w, input logic [SW-1:0] h,
                           input logic [SW-1:0] r, input logic [SW-1:0] s);
    write_reg(bsm_pkg::REG_WIDTH, w);
    write_reg(bsm_pkg::REG_HEIGHT, h);
    write_reg(bsm_pkg::REG_RESERVED, r);
    write_reg(bsm_pkg::REG_STRENGTH, s);
    cfg.valid <= 1'b0;
    phases_run++;
  endtask

  task automatic drain();
    while (pixel_queue.size() > 0 || pix.valid || tone_queue.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // coordinate biased towards the frame edges of one side
  function automatic logic [CW-1:0] pick_coord(input int unsigned dim,
                                               input int unsigned band);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (dim == 0 || r == 0) return CW'($urandom);
    if (r <= 3) return CW'($urandom_range(0, (band < dim) ? band : dim - 1));
    if (r <= 6) return CW'(dim - 1 - $urandom_range(0, (band < dim) ? band : dim - 1));
    return CW'($urandom_range(0, dim - 1));
  endfunction

  task automatic queue_random(input int unsigned count);
    int unsigned w, h, band;
    coord_t p;
    w = (panel_w > bsm_pkg::MAX_DIMENSION) ? bsm_pkg::MAX_DIMENSION : panel_w;
    h = (panel_h > bsm_pkg::MAX_DIMENSION) ? bsm_pkg::MAX_DIMENSION : panel_h;
    band = 3 * ((frame_req != 0) ? frame_req : ((w < h ? w : h) / 15 + 2)) + 2;
    repeat (count) begin
      p.x = pick_coord(w, band);
      p.y = pick_coord(h, band);
      pixel_queue.push_back(p);
    end
  endtask

  task automatic queue_pixel(input int unsigned x, input int unsigned y);
    coord_t p;
    p.x = CW'(x);
    p.y = CW'(y);
    pixel_queue.push_back(p);
  endtask

  // stimulus sequence
  initial begin
    rst_ni      = 1'b0;
    cfg.valid   = 1'b0;
    cfg.index   = '0;
    cfg.data    = '0;
    panel_w     = '0;
    panel_h     = '0;
    frame_req   = '0;
    strength    = '0;
    mismatches  = 0;
    pixels_sent = 0;
    tones_checked = 0;
    phases_run  = 0;
    idle_cycles = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // registers at reset: identity everywhere
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(4095, 0);
    drain();

    // directed: every bezel side, the pip, ties, dial and outside points
    set_panel(64, 48, 0, 65536);
    queue_pixel(0, 0);     queue_pixel(63, 47);  queue_pixel(1, 1);
    queue_pixel(2, 2);     queue_pixel(1, 20);   queue_pixel(20, 1);
    queue_pixel(62, 20);   queue_pixel(20, 46);  queue_pixel(3, 44);
    queue_pixel(60, 46);   queue_pixel(61, 45);  queue_pixel(32, 24);
    queue_pixel(5, 5);     queue_pixel(3, 3);    queue_pixel(58, 42);
    queue_pixel(64, 0);    queue_pixel(0, 48);   queue_pixel(4095, 4095);
    queue_pixel(4095, 10); queue_pixel(10, 4095);
    drain();

    // fixed corners of the register space
    set_panel(4096, 4096, 0, 65536);    queue_random(130); drain();
    set_panel(8191, 5000, 255, 131071); queue_random(130); drain();
    set_panel(2, 2, 0, 1);              queue_random(40);  drain();
    set_panel(5, 7, 0, 65535);          queue_random(60);  drain();
    set_panel(0, 300, 9, 40000);        queue_random(40);  drain();
    set_panel(640, 480, 0, 0);          queue_random(40);  drain();
    set_panel(600, 400, 255, 65536);    queue_random(130); drain();
    set_panel(3, 4096, 1, 65536);       queue_random(60);  drain();

    // random settings, mostly small panels
    repeat (7) begin
      set_panel(SW'(($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 300)),
                SW'(($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 300)),
                SW'(($urandom_range(0, 1) == 0) ? 0 : $urandom),
                SW'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 65536)));
      queue_random(100);
      drain();
    end

    $display("%0d pixels over %0d register settings, %0d results checked, %0d mismatches",
             pixels_sent, phases_run, tones_checked, mismatches);
    if (mismatches == 0 && tone_queue.size() == 0) begin
      $display("PASS bezel_shadow_mask_pixel_core");
    end else begin
      $display("FAIL bezel_shadow_mask_pixel_core");
    end
    $finish;
  end

endmodule

FILE: bezel_shadow_mask_pixel_core.f
rtl/core/bsm_pkg.sv
rtl/core/bsm_if.sv
rtl/core/bezel_shadow_mask_pixel_core.sv
sim/tb_bezel_shadow_mask_pixel_core.sv
